FILE: rtl/stbs_pkg.sv
// Shared types and constants for the s-expression token boundary scanner.
// Used by stbs_classify, stbs_step and sexpr_token_boundary_scanner.
package stbs_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_COMMA   = 3'd1,
        MODE_STRING  = 3'd2,
        MODE_ESCAPE  = 3'd3,
        MODE_COMMENT = 3'd4,
        MODE_ATOM    = 3'd5
    } scan_mode_t;

    localparam logic [3:0] KIND_COMMA  = 4'd12;
    localparam logic [3:0] KIND_STRING = 4'd13;
    localparam logic [3:0] KIND_ATOM   = 4'd14;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef struct packed {
        logic       is_zero;
        logic       is_blank;
        logic       is_newline;
        logic       is_single;
        logic [3:0] single_kind;
        logic       is_comma;
        logic       is_quote;
        logic       is_semi;
        logic       is_at;
        logic       is_bslash;
        logic       ends_atom;
    } byte_class_t;

    typedef struct packed {
        logic       ended_before;
        logic       started;
        logic [3:0] start_kind;
        logic       ended_here;
        logic       splicing;
        logic       unterminated;
        logic       end_of_text;
    } scan_result_t;

endpackage

FILE: rtl/stbs_classify.sv
// Byte classifier: sorts one source byte into the character classes of the scanner.
// Depends on stbs_pkg.
module stbs_classify (
    input  logic [7:0]           text_byte,
    output stbs_pkg::byte_class_t cls
);
    import stbs_pkg::*;

    logic       single;
    logic [3:0] single_kind;

    always_comb begin
        single      = 1'b1;
        single_kind = 4'd0;
        unique case (text_byte)
            8'h28:   single_kind = 4'd0;
            8'h29:   single_kind = 4'd1;
            8'h7B:   single_kind = 4'd2;
            8'h7D:   single_kind = 4'd3;
            8'h5B:   single_kind = 4'd4;
            8'h5D:   single_kind = 4'd5;
            8'h27:   single_kind = 4'd6;
            8'h60:   single_kind = 4'd7;
            8'h21:   single_kind = 4'd8;
            8'h3A:   single_kind = 4'd9;
            8'h26:   single_kind = 4'd10;
            8'h2E:   single_kind = 4'd11;
            default: single      = 1'b0;
        endcase
    end

    always_comb begin
        cls.is_zero     = (text_byte == CH_NUL);
        cls.is_newline  = (text_byte == CH_LF);
        cls.is_blank    = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
                          (text_byte == CH_CR) || (text_byte == CH_LF);
        cls.is_single   = single;
        cls.single_kind = single_kind;
        cls.is_comma    = (text_byte == CH_COMMA);
        cls.is_quote    = (text_byte == CH_QUOTE);
        cls.is_semi     = (text_byte == CH_SEMI);
        cls.is_at       = (text_byte == CH_AT);
        cls.is_bslash   = (text_byte == CH_BSLASH);
        // brackets only: quote, backtick and the other single tokens do not end an atom
        cls.ends_atom   = cls.is_zero || cls.is_blank || cls.is_semi ||
                          (single && (single_kind <= 4'd5));
    end

endmodule

FILE: rtl/stbs_step.sv
// Scan mode register and per-byte state machine of the token boundary scanner.
// Depends on stbs_pkg; takes the byte class from stbs_classify.
module stbs_step (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  stbs_pkg::byte_class_t  cls,
    output stbs_pkg::scan_result_t res
);
    import stbs_pkg::*;

    scan_mode_t   mode_reg;
    scan_mode_t   mode_next;
    scan_mode_t   idle_next;
    scan_result_t idle_res;

    // handling of a byte seen between tokens
    always_comb begin
        idle_res  = '0;
        idle_next = MODE_IDLE;
        priority if (cls.is_zero) begin
            idle_res.end_of_text = 1'b1;
        end else if (cls.is_blank) begin
            idle_next = MODE_IDLE;
        end else if (cls.is_single) begin
            idle_res.started    = 1'b1;
            idle_res.start_kind = cls.single_kind;
            idle_res.ended_here = 1'b1;
        end else if (cls.is_comma) begin
            idle_res.started    = 1'b1;
            idle_res.start_kind = KIND_COMMA;
            idle_next           = MODE_COMMA;
        end else if (cls.is_quote) begin
            idle_res.started    = 1'b1;
            idle_res.start_kind = KIND_STRING;
            idle_next           = MODE_STRING;
        end else if (cls.is_semi) begin
            idle_next = MODE_COMMENT;
        end else begin
            idle_res.started    = 1'b1;
            idle_res.start_kind = KIND_ATOM;
            idle_next           = MODE_ATOM;
        end
    end

    always_comb begin
        unique case (mode_reg)
            MODE_COMMA:   mode_next = cls.is_at ? MODE_IDLE : idle_next;
            MODE_STRING: begin
                priority if (cls.is_zero || cls.is_quote) mode_next = MODE_IDLE;
                else if (cls.is_bslash)                   mode_next = MODE_ESCAPE;
                else                                      mode_next = MODE_STRING;
            end
            MODE_ESCAPE:  mode_next = cls.is_zero ? MODE_IDLE : MODE_STRING;
            MODE_COMMENT: mode_next = (cls.is_zero || cls.is_newline) ? MODE_IDLE
                                                                      : MODE_COMMENT;
            MODE_ATOM:    mode_next = cls.ends_atom ? idle_next : MODE_ATOM;
            default:      mode_next = idle_next;
        endcase
    end

    always_comb begin
        res = '0;
        unique case (mode_reg)
            MODE_COMMA: begin
                if (cls.is_at) begin
                    res.splicing   = 1'b1;
                    res.ended_here = 1'b1;
                end else begin
                    res              = idle_res;
                    res.ended_before = 1'b1;
                end
            end
            MODE_STRING: begin
                res.unterminated = cls.is_zero;
                res.end_of_text  = cls.is_zero;
                res.ended_here   = cls.is_quote;
            end
            MODE_ESCAPE: begin
                res.unterminated = cls.is_zero;
                res.end_of_text  = cls.is_zero;
            end
            MODE_COMMENT: res.end_of_text = cls.is_zero;
            MODE_ATOM: begin
                if (cls.ends_atom) begin
                    res              = idle_res;
                    res.ended_before = 1'b1;
                end
            end
            default: res = idle_res;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
        end else if (advance) begin
            mode_reg <= mode_next;
        end
    end

`ifndef SYNTH
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> mode_reg == MODE_IDLE)
        else $error("scan mode not idle after reset");
    a_hold_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(mode_reg))
        else $error("scan mode moved without a word");
    a_eot_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res.end_of_text |=> mode_reg == MODE_IDLE)
        else $error("scan mode not idle after end of text");
    a_unterm_src: assert property (@(posedge aclk) disable iff (!aresetn)
        res.unterminated |-> (mode_reg == MODE_STRING || mode_reg == MODE_ESCAPE))
        else $error("unterminated flagged outside a string");
    a_splice_src: assert property (@(posedge aclk) disable iff (!aresetn)
        res.splicing |-> (mode_reg == MODE_COMMA && res.ended_here && !res.started))
        else $error("splicing flagged outside a comma token");
`endif

endmodule

FILE: rtl/sexpr_token_boundary_scanner.sv
// Top level of the s-expression token boundary scanner.
// Depends on stbs_pkg, stbs_classify and stbs_step.
//
// Usage:
//   Source text enters one byte per word on the s_ channel (s_valid, s_ready,
//   s_text_byte); byte 0 ends a text and the next byte begins a new one.
//   Each accepted byte yields exactly one result word on the m_ channel
//   (m_valid, m_ready and the boundary flags), in input order.
//   Path: an accepted byte waits in the input register until the result
//   register is empty or being taken, then its result word moves into the
//   result register and is presented on the m_ channel.
//   Throughput: one byte per cycle unless m_ready stalls; the scan mode
//   update is one small state machine step between the two registers.
//   Stall: when m_ready is low the result register holds its word and the
//   input register can still take one more byte; s_ready drops only when
//   both are full.
//   Reset: aresetn, synchronous and active low, empties both registers and
//   returns the scan mode to idle between tokens.
module sexpr_token_boundary_scanner (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_ended_before,
    output logic       m_started,
    output logic [3:0] m_start_kind,
    output logic       m_ended_here,
    output logic       m_splicing,
    output logic       m_unterminated,
    output logic       m_end_of_text
);
    import stbs_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   byte_reg;
    logic         out_valid_reg;
    scan_result_t res_reg;
    logic         advance;
    byte_class_t  cls;
    scan_result_t res;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    stbs_classify u_classify (
        .text_byte (byte_reg),
        .cls       (cls)
    );

    stbs_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .cls     (cls),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_text_byte;
        end
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_ended_before = res_reg.ended_before;
    assign m_started      = res_reg.started;
    assign m_start_kind   = res_reg.start_kind;
    assign m_ended_here   = res_reg.ended_here;
    assign m_splicing     = res_reg.splicing;
    assign m_unterminated = res_reg.unterminated;
    assign m_end_of_text  = res_reg.end_of_text;

endmodule

FILE: tb/sexpr_token_boundary_scanner_tb.sv
// Testbench for sexpr_token_boundary_scanner: drives source bytes, predicts the boundary flags
// of every result word and compares them field by field, under varied back-pressure.
// Depends on stbs_pkg and the RTL of the scanner.
module sexpr_token_boundary_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stbs_pkg::*;

    localparam int          RESET_CYCLES    = 11;
    localparam int          PHASE_WORDS     = 380;
    localparam int          HOLD_CYCLES     = 60;
    localparam int          DRAIN_CYCLES    = 4;
    localparam int          WATCHDOG_LIMIT  = 2000;
    localparam logic [3:0]  KIND_OPEN_PAREN  = 4'd0;
    localparam logic [3:0]  KIND_CLOSE_PAREN = 4'd1;

    typedef struct packed {
        logic [7:0]   text;
        logic         typed;
        scan_result_t want;
    } dir_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_text_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b1;
    logic       m_ended_before;
    logic       m_started;
    logic [3:0] m_start_kind;
    logic       m_ended_here;
    logic       m_splicing;
    logic       m_unterminated;
    logic       m_end_of_text;

    scan_mode_t   tracked_mode = MODE_IDLE;
    scan_result_t expected_results [$];
    dir_row_t     directed_rows [$];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_request = 1'b0;
    int  sent_count = 0;
    int  phase_sent = 0;
    int  checked_count = 0;
    int  error_count = 0;
    int  hold_count = 0;
    int  quiet_cycles = 0;

    sexpr_token_boundary_scanner dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_text_byte    (s_text_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_ended_before (m_ended_before),
        .m_started      (m_started),
        .m_start_kind   (m_start_kind),
        .m_ended_here   (m_ended_here),
        .m_splicing     (m_splicing),
        .m_unterminated (m_unterminated),
        .m_end_of_text  (m_end_of_text)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [7:0] single_byte(input int unsigned k);
        case (k)
            0: return "(";
            1: return ")";
            2: return "{";
            3: return "}";
            4: return "[";
            5: return "]";
            6: return "'";
            7: return 8'h60;
            8: return "!";
            9: return ":";
            10: return "&";
            default: return ".";
        endcase
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
    endfunction

    function automatic logic ends_atom(input logic [7:0] b);
        return b == CH_NUL || is_blank(b) || b == CH_SEMI || b == "(" || b == ")" ||
               b == "{" || b == "}" || b == "[" || b == "]";
    endfunction

    function automatic scan_mode_t between_tokens(input logic [7:0] b, inout scan_result_t r);
        if (b == CH_NUL) begin
            r.end_of_text = 1'b1;
            return MODE_IDLE;
        end
        if (is_blank(b))
            return MODE_IDLE;
        for (int unsigned k = 0; k < 12; k++) begin
            if (single_byte(k) == b) begin
                r.started    = 1'b1;
                r.start_kind = 4'(k);
                r.ended_here = 1'b1;
                return MODE_IDLE;
            end
        end
        if (b == CH_COMMA) begin
            r.started    = 1'b1;
            r.start_kind = KIND_COMMA;
            return MODE_COMMA;
        end
        if (b == CH_QUOTE) begin
            r.started    = 1'b1;
            r.start_kind = KIND_STRING;
            return MODE_STRING;
        end
        if (b == CH_SEMI)
            return MODE_COMMENT;
        r.started    = 1'b1;
        r.start_kind = KIND_ATOM;
        return MODE_ATOM;
    endfunction

    function automatic scan_result_t mark_boundaries(input logic [7:0] b);
        scan_result_t r;
        scan_mode_t   nxt;
        r = '0;
        case (tracked_mode)
            MODE_COMMA: begin
                if (b == CH_AT) begin
                    r.splicing   = 1'b1;
                    r.ended_here = 1'b1;
                    nxt = MODE_IDLE;
                end else begin
                    r.ended_before = 1'b1;
                    nxt = between_tokens(b, r);
                end
            end
            MODE_STRING: begin
                if (b == CH_NUL) begin
                    r.unterminated = 1'b1;
                    r.end_of_text  = 1'b1;
                    nxt = MODE_IDLE;
                end else if (b == CH_BSLASH) begin
                    nxt = MODE_ESCAPE;
                end else if (b == CH_QUOTE) begin
                    r.ended_here = 1'b1;
                    nxt = MODE_IDLE;
                end else begin
                    nxt = MODE_STRING;
                end
            end
            MODE_ESCAPE: begin
                if (b == CH_NUL) begin
                    r.unterminated = 1'b1;
                    r.end_of_text  = 1'b1;
                    nxt = MODE_IDLE;
                end else begin
                    nxt = MODE_STRING;
                end
            end
            MODE_COMMENT: begin
                if (b == CH_NUL) begin
                    r.end_of_text = 1'b1;
                    nxt = MODE_IDLE;
                end else if (b == CH_LF) begin
                    nxt = MODE_IDLE;
                end else begin
                    nxt = MODE_COMMENT;
                end
            end
            MODE_ATOM: begin
                if (ends_atom(b)) begin
                    r.ended_before = 1'b1;
                    nxt = between_tokens(b, r);
                end else begin
                    nxt = MODE_ATOM;
                end
            end
            default: begin
                nxt = between_tokens(b, r);
            end
        endcase
        tracked_mode = nxt;
        return r;
    endfunction

    function automatic scan_result_t flags(input logic eb, input logic st, input logic [3:0] kind,
                                           input logic eh, input logic sp, input logic un,
                                           input logic eot);
        return {eb, st, kind, eh, sp, un, eot};
    endfunction

    task automatic add_row(input logic [7:0] b, input logic typed, input scan_result_t want);
        directed_rows.push_back('{text: b, typed: typed, want: want});
    endtask

    task automatic build_directed_rows();
        add_row(CH_NUL,    1'b1, flags(1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0, 1'b1));
        add_row("(",       1'b1, flags(1'b0, 1'b1, KIND_OPEN_PAREN, 1'b1, 1'b0, 1'b0, 1'b0));
        add_row(")",       1'b1, flags(1'b0, 1'b1, KIND_CLOSE_PAREN, 1'b1, 1'b0, 1'b0, 1'b0));
        add_row(CH_COMMA,  1'b0, '0);
        add_row(CH_AT,     1'b1, flags(1'b0, 1'b0, '0, 1'b1, 1'b1, 1'b0, 1'b0));
        add_row(CH_COMMA,  1'b0, '0);
        add_row("a",       1'b0, '0);
        add_row(".",       1'b0, '0);
        add_row(CH_TAB,    1'b0, '0);
        add_row(CH_SEMI,   1'b0, '0);
        add_row("x",       1'b0, '0);
        add_row(CH_LF,     1'b0, '0);
        add_row(CH_QUOTE,  1'b0, '0);
        add_row(CH_BSLASH, 1'b0, '0);
        add_row(CH_QUOTE,  1'b0, '0);
        add_row(CH_QUOTE,  1'b0, '0);
        add_row(8'hFF,     1'b0, '0);
        add_row(CH_NUL,    1'b1, flags(1'b1, 1'b0, '0, 1'b0, 1'b0, 1'b0, 1'b1));
        add_row(CH_QUOTE,  1'b0, '0);
        add_row(CH_NUL,    1'b1, flags(1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b1, 1'b1));
        add_row(CH_QUOTE,  1'b0, '0);
        add_row(CH_BSLASH, 1'b0, '0);
        add_row(CH_NUL,    1'b1, flags(1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b1, 1'b1));
        add_row(CH_SEMI,   1'b0, '0);
        add_row(CH_NUL,    1'b1, flags(1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0, 1'b1));
    endtask

    // hold valid and the byte until the word is taken, then log its prediction
    task automatic send_word(input logic [7:0] b, input logic typed, input scan_result_t want);
        scan_result_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_text_byte <= b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predicted = mark_boundaries(b);
        expected_results.push_back(typed ? want : predicted);
        sent_count++;
        phase_sent++;
    endtask

    task automatic send_text(input logic [7:0] b);
        send_word(b, 1'b0, '0);
    endtask

    function automatic logic [7:0] atom_char();
        string pool;
        pool = "abcdefghijklmnopqrstuvwxyzQZ0123456789-+*/<>=?_#$%^~|";
        if ($urandom_range(7) == 0)
            return 8'($urandom_range(8'h80, 8'hFF));
        return pool[$urandom_range(pool.len() - 1)];
    endfunction

    task automatic emit_fragment();
        int pick;
        int len;
        pick = $urandom_range(99);
        if (pick < 25) begin
            len = $urandom_range(1, 6);
            repeat (len) send_text(atom_char());
        end else if (pick < 40) begin
            send_text(CH_QUOTE);
            len = $urandom_range(0, 6);
            repeat (len) begin
                if ($urandom_range(4) == 0) begin
                    send_text(CH_BSLASH);
                    send_text(8'($urandom_range(1, 255)));
                end else begin
                    send_text(atom_char());
                end
            end
            if ($urandom_range(9) != 0)
                send_text(CH_QUOTE);
        end else if (pick < 50) begin
            send_text(CH_COMMA);
            if ($urandom_range(1) == 0)
                send_text(CH_AT);
        end else if (pick < 65) begin
            send_text(single_byte($urandom_range(11)));
        end else if (pick < 76) begin
            len = $urandom_range(1, 3);
            repeat (len) begin
                case ($urandom_range(3))
                    0: send_text(CH_SPACE);
                    1: send_text(CH_TAB);
                    2: send_text(CH_CR);
                    default: send_text(CH_LF);
                endcase
            end
        end else if (pick < 84) begin
            send_text(CH_SEMI);
            len = $urandom_range(0, 5);
            repeat (len) send_text(atom_char());
            send_text(($urandom_range(3) == 0) ? CH_NUL : CH_LF);
        end else if (pick < 89) begin
            send_text(CH_NUL);
        end else begin
            send_text(8'($urandom_range(0, 255)));
        end
    endtask

    // receiver: random stalls, and one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
                hold_count++;
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        scan_result_t got;
        scan_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_ended_before, m_started, m_start_kind, m_ended_here,
                   m_splicing, m_unterminated, m_end_of_text};
            if (expected_results.size() == 0) begin
                $display("%0t: result word %b with nothing expected", $time, got);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("ended_before", int'(want.ended_before), int'(got.ended_before));
                check_field("started", int'(want.started), int'(got.started));
                check_field("start_kind", int'(want.start_kind), int'(got.start_kind));
                check_field("ended_here", int'(want.ended_here), int'(got.ended_here));
                check_field("splicing", int'(want.splicing), int'(got.splicing));
                check_field("unterminated", int'(want.unterminated), int'(got.unterminated));
                check_field("end_of_text", int'(want.end_of_text), int'(got.end_of_text));
                checked_count++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("sexpr_token_boundary_scanner verification failed");
                $finish;
            end
        end
    end

    initial begin
        int directed_count;
        build_directed_rows();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed_rows[i])
            send_word(directed_rows[i].text, directed_rows[i].typed, directed_rows[i].want);
        directed_count = sent_count;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_request   = 1'b1;
                end
                1: begin
                    send_idle_pct  = 67;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 67;
                end
                default: begin
                    send_idle_pct  = 38;
                    recv_stall_pct = 38;
                end
            endcase
            phase_sent = 0;
            while (phase_sent < PHASE_WORDS)
                emit_fragment();
        end
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d bytes (%0d directed), checked %0d result words, %0d mismatches.",
                 sent_count, directed_count, checked_count, error_count);
        $display("Covered four idling mixes and %0d long output hold-off(s).", hold_count);
        if (error_count == 0) begin
            $display("sexpr_token_boundary_scanner verification clean");
        end else begin
            $display("sexpr_token_boundary_scanner verification failed");
        end
        $finish;
    end
endmodule

FILE: files.f
rtl/stbs_pkg.sv
rtl/stbs_classify.sv
rtl/stbs_step.sv
rtl/sexpr_token_boundary_scanner.sv
tb/sexpr_token_boundary_scanner_tb.sv
